// ----- sv/pbac_pkg.sv -----
// Shared widths, types and register codes for the bond angle cosine pipeline.
package pbac_pkg;

  localparam int CoordBits = 24;
  localparam int BoxBits   = CoordBits - 1;
  localparam int DiffBits  = CoordBits + 1;
  localparam int VecBits   = CoordBits + 2;
  localparam int MagBits   = CoordBits + 1;
  localparam int LenBits   = 2 * CoordBits + 2;
  localparam int HalfBits  = LenBits / 2;
  localparam int ProdBits  = 2 * LenBits;
  localparam int RemBits   = ProdBits + 1;
  localparam int CosBits   = 16;
  localparam int CosFrac   = CosBits - 1;
  localparam int QBits     = 2 * CosFrac + 1;
  localparam int RootBits  = CosFrac + 1;
  localparam int TrialBits = 2 * RootBits + 1;

  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = BoxBits;

  localparam logic [CfgIdxBits-1:0] CfgPeriodic = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgBoxX     = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgBoxY     = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgBoxZ     = 2'd3;

  typedef struct packed {
    logic signed [CoordBits-1:0] p0_x;
    logic signed [CoordBits-1:0] p0_y;
    logic signed [CoordBits-1:0] p0_z;
    logic signed [CoordBits-1:0] p1_x;
    logic signed [CoordBits-1:0] p1_y;
    logic signed [CoordBits-1:0] p1_z;
    logic signed [CoordBits-1:0] p2_x;
    logic signed [CoordBits-1:0] p2_y;
    logic signed [CoordBits-1:0] p2_z;
  } in_item_t;

  typedef struct packed {
    logic [LenBits-1:0]        bond_a_len_sq;
    logic [LenBits-1:0]        bond_b_len_sq;
    logic signed [CosBits-1:0] cos_value;
    logic                      degenerate;
  } out_item_t;

  typedef struct packed {
    logic [LenBits-1:0] la;
    logic [LenBits-1:0] lb;
    logic               neg;
    logic               degen;
  } side_t;

endpackage

// ----- sv/pbac_cos_unit.sv -----
// Pipelined restoring divider and integer square root that produce the cosine magnitude.
module pbac_cos_unit import pbac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [ProdBits-1:0] ab_i,
  input  logic [ProdBits-1:0] dd_i,
  input  side_t               side_i,
  output logic                valid_o,
  output logic [RootBits-1:0] root_o,
  output side_t               side_o
);

  localparam int DivSteps = QBits;
  localparam int SqSteps  = RootBits;
  localparam int Stages   = DivSteps + SqSteps;

  logic [Stages-1:0]   v_q;
  side_t               side_q [Stages];
  logic [ProdBits-1:0] ab_q   [DivSteps-1];
  logic [ProdBits-1:0] rem_q  [DivSteps-1];
  logic [QBits-1:0]    quo_q  [DivSteps];
  logic [QBits-1:0]    srem_q [SqSteps-1];
  logic [RootBits-1:0] root_q [SqSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < Stages; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q[0] <= ab_i;
      if (dd_i >= ab_i) begin
        rem_q[0] <= dd_i - ab_i;
        quo_q[0] <= QBits'(1);
      end else begin
        rem_q[0] <= dd_i;
        quo_q[0] <= '0;
      end
    end
  end

  for (genvar j = 1; j < DivSteps; j++) begin : g_div
    logic [RemBits-1:0] t;
    logic [RemBits-1:0] diff;
    logic               ge;
    assign t    = {rem_q[j-1], 1'b0};
    assign ge   = t >= {1'b0, ab_q[j-1]};
    assign diff = t - {1'b0, ab_q[j-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= {quo_q[j-1][QBits-2:0], ge};
      end
    end
    if (j < DivSteps - 1) begin : g_ab
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ab_q[j]  <= ab_q[j-1];
          rem_q[j] <= ge ? diff[ProdBits-1:0] : t[ProdBits-1:0];
        end
      end
    end
  end

  for (genvar s = 0; s < SqSteps; s++) begin : g_sqrt
    localparam int B = SqSteps - 1 - s;
    logic [QBits-1:0]     rin;
    logic [RootBits-1:0]  min;
    logic [TrialBits-1:0] trial;
    logic [TrialBits-1:0] rext;
    logic                 ge;
    if (s == 0) begin : g_first
      assign rin = quo_q[DivSteps-1];
      assign min = '0;
    end else begin : g_next
      assign rin = srem_q[s-1];
      assign min = root_q[s-1];
    end
    assign trial = (TrialBits'(min) << (B + 1)) + (TrialBits'(1) << (2 * B));
    assign rext  = TrialBits'(rin);
    assign ge    = rext >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= ge ? (min | (RootBits'(1) << B)) : min;
      end
    end
    if (s < SqSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          srem_q[s] <= ge ? QBits'(rext - trial) : rin;
        end
      end
    end
  end

  assign valid_o = v_q[Stages-1];
  assign root_o  = root_q[SqSteps-1];
  assign side_o  = side_q[Stages-1];

endmodule

// ----- sv/periodic_bond_angle_cosine.sv -----
// Top level: minimum-image bond vectors, squared lengths and bond angle cosine.
//
//   channel  signals                        item
//   in       in_valid_i / in_ready_o        in_item_t, three atom positions
//   out      out_valid_o / out_ready_i      out_item_t, lengths, cosine, flag
//   cfg      cfg_we_i, cfg_idx_i            periodic_mode, box_x, box_y, box_z
//
// One item enters per cycle unless the output stalls; on its way to the output
// register it passes the 31 divider stages and 16 square root stages.
// Reset clears all valid bits and loads free boundaries and maximal boxes.
// A stalled output freezes the whole pipeline; no item is lost or repeated.
module periodic_bond_angle_cosine import pbac_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  logic               periodic_q;
  logic [BoxBits-1:0] box_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= 1'b0;
      box_q[0]   <= '1;
      box_q[1]   <= '1;
      box_q[2]   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPeriodic: periodic_q <= cfg_wdata_i[0];
        CfgBoxX:     box_q[0]   <= cfg_wdata_i;
        CfgBoxY:     box_q[1]   <= cfg_wdata_i;
        CfgBoxZ:     box_q[2]   <= cfg_wdata_i;
        default:     periodic_q <= periodic_q;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  out_item_t out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic signed [CoordBits-1:0] p0 [3];
  logic signed [CoordBits-1:0] p1 [3];
  logic signed [CoordBits-1:0] p2 [3];

  assign p0[0] = in_i.p0_x;
  assign p0[1] = in_i.p0_y;
  assign p0[2] = in_i.p0_z;
  assign p1[0] = in_i.p1_x;
  assign p1[1] = in_i.p1_y;
  assign p1[2] = in_i.p1_z;
  assign p2[0] = in_i.p2_x;
  assign p2[1] = in_i.p2_y;
  assign p2[2] = in_i.p2_z;

  logic [7:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:0], in_valid_i};
    end
  end

  logic signed [DiffBits-1:0] da_q [3];
  logic signed [DiffBits-1:0] db_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        da_q[k] <= DiffBits'(p1[k]) - DiffBits'(p0[k]);
        db_q[k] <= DiffBits'(p2[k]) - DiffBits'(p1[k]);
      end
    end
  end

  logic signed [VecBits-1:0] va_d [3];
  logic signed [VecBits-1:0] vb_d [3];
  logic signed [VecBits-1:0] va_q [3];
  logic signed [VecBits-1:0] vb_q [3];

  always_comb begin
    logic signed [VecBits-1:0] tw;
    logic signed [VecBits-1:0] bs;
    logic signed [VecBits-1:0] dv;
    for (int k = 0; k < 3; k++) begin
      bs = $signed({{(VecBits-BoxBits){1'b0}}, box_q[k]});
      tw = $signed({da_q[k], 1'b0});
      dv = VecBits'(da_q[k]);
      priority if (periodic_q && (tw > bs)) begin
        va_d[k] = dv - bs;
      end else if (periodic_q && (tw < -bs)) begin
        va_d[k] = dv + bs;
      end else begin
        va_d[k] = dv;
      end
      tw = $signed({db_q[k], 1'b0});
      dv = VecBits'(db_q[k]);
      priority if (periodic_q && (tw > bs)) begin
        vb_d[k] = dv - bs;
      end else if (periodic_q && (tw < -bs)) begin
        vb_d[k] = dv + bs;
      end else begin
        vb_d[k] = dv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      va_q <= va_d;
      vb_q <= vb_d;
    end
  end

  logic [MagBits-1:0] ma_q [3];
  logic [MagBits-1:0] mb_q [3];
  logic [2:0]         xneg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ma_q[k]   <= va_q[k][VecBits-1] ? MagBits'(-va_q[k]) : MagBits'(va_q[k]);
        mb_q[k]   <= vb_q[k][VecBits-1] ? MagBits'(-vb_q[k]) : MagBits'(vb_q[k]);
        xneg_q[k] <= va_q[k][VecBits-1] ^ vb_q[k][VecBits-1];
      end
    end
  end

  logic [LenBits-1:0] pa_q [3];
  logic [LenBits-1:0] pb_q [3];
  logic [LenBits-1:0] px_q [3];
  logic [2:0]         xneg4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa_q[k] <= LenBits'(ma_q[k]) * LenBits'(ma_q[k]);
        pb_q[k] <= LenBits'(mb_q[k]) * LenBits'(mb_q[k]);
        px_q[k] <= LenBits'(ma_q[k]) * LenBits'(mb_q[k]);
      end
      xneg4_q <= xneg_q;
    end
  end

  logic [LenBits-1:0] la5_q, lb5_q, pos5_q, neg5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      la5_q  <= pa_q[0] + pa_q[1] + pa_q[2];
      lb5_q  <= pb_q[0] + pb_q[1] + pb_q[2];
      pos5_q <= (xneg4_q[0] ? '0 : px_q[0]) + (xneg4_q[1] ? '0 : px_q[1])
              + (xneg4_q[2] ? '0 : px_q[2]);
      neg5_q <= (xneg4_q[0] ? px_q[0] : '0) + (xneg4_q[1] ? px_q[1] : '0)
              + (xneg4_q[2] ? px_q[2] : '0);
    end
  end

  side_t              side6_q, side7_q, side8_q;
  logic [LenBits-1:0] dm6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side6_q.la    <= la5_q;
      side6_q.lb    <= lb5_q;
      side6_q.neg   <= pos5_q < neg5_q;
      side6_q.degen <= (la5_q == '0) || (lb5_q == '0);
      dm6_q         <= (pos5_q < neg5_q) ? (neg5_q - pos5_q) : (pos5_q - neg5_q);
    end
  end

  logic [LenBits-1:0] ab_ll_q, ab_lh_q, ab_hl_q, ab_hh_q;
  logic [LenBits-1:0] dd_ll_q, dd_lh_q, dd_hh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side7_q <= side6_q;
      ab_ll_q <= LenBits'(side6_q.la[HalfBits-1:0]) * LenBits'(side6_q.lb[HalfBits-1:0]);
      ab_lh_q <= LenBits'(side6_q.la[HalfBits-1:0]) * LenBits'(side6_q.lb[LenBits-1:HalfBits]);
      ab_hl_q <= LenBits'(side6_q.la[LenBits-1:HalfBits]) * LenBits'(side6_q.lb[HalfBits-1:0]);
      ab_hh_q <= LenBits'(side6_q.la[LenBits-1:HalfBits])
               * LenBits'(side6_q.lb[LenBits-1:HalfBits]);
      dd_ll_q <= LenBits'(dm6_q[HalfBits-1:0]) * LenBits'(dm6_q[HalfBits-1:0]);
      dd_lh_q <= LenBits'(dm6_q[HalfBits-1:0]) * LenBits'(dm6_q[LenBits-1:HalfBits]);
      dd_hh_q <= LenBits'(dm6_q[LenBits-1:HalfBits]) * LenBits'(dm6_q[LenBits-1:HalfBits]);
    end
  end

  logic [ProdBits-1:0] ab8_q, dd8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side8_q <= side7_q;
      ab8_q   <= (ProdBits'(ab_hh_q) << LenBits)
               + ((ProdBits'(ab_lh_q) + ProdBits'(ab_hl_q)) << HalfBits)
               + ProdBits'(ab_ll_q);
      dd8_q   <= (ProdBits'(dd_hh_q) << LenBits)
               + (ProdBits'(dd_lh_q) << (HalfBits + 1))
               + ProdBits'(dd_ll_q);
    end
  end

  logic                u_valid;
  logic [RootBits-1:0] u_root;
  side_t               u_side;

  pbac_cos_unit u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[7]),
    .ab_i    (ab8_q),
    .dd_i    (dd8_q),
    .side_i  (side8_q),
    .valid_o (u_valid),
    .root_o  (u_root),
    .side_o  (u_side)
  );

  logic signed [CosBits-1:0] cos_d;

  always_comb begin
    priority if (u_side.degen) begin
      cos_d = '0;
    end else if (u_side.neg) begin
      cos_d = $signed(CosBits'(~u_root + RootBits'(1)));
    end else if (u_root[RootBits-1]) begin
      cos_d = $signed({1'b0, {(CosBits-1){1'b1}}});
    end else begin
      cos_d = $signed(CosBits'(u_root));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= u_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.bond_a_len_sq <= u_side.la;
      out_q.bond_b_len_sq <= u_side.lb;
      out_q.cos_value     <= cos_d;
      out_q.degenerate    <= u_side.degen;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.degenerate |-> out_q.cos_value == '0)
    else $error("degenerate item with nonzero cosine");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the output is stalled");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_valid && !u_side.degen |-> u_root <= (RootBits'(1) << CosFrac))
    else $error("cosine magnitude above one");

endmodule

// ----- sim/tb_periodic_bond_angle_cosine.sv -----
// Testbench for the bond angle cosine block: random and directed items, scored by a predictor.
module tb_periodic_bond_angle_cosine;
  import pbac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class cosine_scoreboard;
    bit              periodic;
    bit [BoxBits-1:0] box [3];
    out_item_t       pending [$];
    int              errors;

    function new();
      periodic = 1'b0;
      for (int k = 0; k < 3; k++) box[k] = '1;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
      case (idx)
        CfgPeriodic: periodic = val[0];
        CfgBoxX:     box[0] = val;
        CfgBoxY:     box[1] = val;
        CfgBoxZ:     box[2] = val;
        default: ;
      endcase
    endfunction

    function longint wrap(longint d, longint bx);
      if (!periodic) return d;
      if (2 * d > bx) return d - bx;
      if (2 * d < -bx) return d + bx;
      return d;
    endfunction

    function void note_input(in_item_t it);
      longint c0 [3], c1 [3], c2 [3], va [3], vb [3];
      logic signed [127:0] la, lb, dot, dm;
      logic [255:0] lhs, rhs, ab;
      logic [16:0] m, c;
      out_item_t r;
      c0 = '{longint'(it.p0_x), longint'(it.p0_y), longint'(it.p0_z)};
      c1 = '{longint'(it.p1_x), longint'(it.p1_y), longint'(it.p1_z)};
      c2 = '{longint'(it.p2_x), longint'(it.p2_y), longint'(it.p2_z)};
      la = 0; lb = 0; dot = 0;
      for (int k = 0; k < 3; k++) begin
        va[k] = wrap(c1[k] - c0[k], longint'(box[k]));
        vb[k] = wrap(c2[k] - c1[k], longint'(box[k]));
        la += 128'(va[k]) * 128'(va[k]);
        lb += 128'(vb[k]) * 128'(vb[k]);
        dot += 128'(va[k]) * 128'(vb[k]);
      end
      r.bond_a_len_sq = la[LenBits-1:0];
      r.bond_b_len_sq = lb[LenBits-1:0];
      r.cos_value = '0;
      r.degenerate = (la == 0) || (lb == 0);
      if (!r.degenerate) begin
        dm = dot < 0 ? -dot : dot;
        rhs = 256'(dm) * 256'(dm) << 30;
        ab = 256'(la) * 256'(lb);
        m = 0;
        for (int b = 15; b >= 0; b--) begin
          c = m | (17'd1 << b);
          lhs = 256'(c) * 256'(c) * ab;
          if (lhs <= rhs) m = c;
        end
        if (dot < 0) r.cos_value = -16'(m);
        else r.cos_value = (m > 32767) ? 16'sd32767 : 16'(m);
      end
      pending.push_back(r);
    endfunction

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result");
        return;
      end
      want = pending.pop_front();
      if (got.bond_a_len_sq !== want.bond_a_len_sq)
        report($sformatf("len a got %0d want %0d", got.bond_a_len_sq, want.bond_a_len_sq));
      if (got.bond_b_len_sq !== want.bond_b_len_sq)
        report($sformatf("len b got %0d want %0d", got.bond_b_len_sq, want.bond_b_len_sq));
      if (got.cos_value !== want.cos_value)
        report($sformatf("cos got %0d want %0d", got.cos_value, want.cos_value));
      if (got.degenerate !== want.degenerate)
        report($sformatf("degenerate got %0b want %0b", got.degenerate, want.degenerate));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = CfgPeriodic;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;

  cosine_scoreboard sb = new();
  bit stim_done = 1'b0;

  periodic_bond_angle_cosine dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [CoordBits-1:0] any_coord();
    case ($urandom_range(0, 4))
      0: return {1'b0, {(CoordBits-1){1'b1}}};
      1: return {1'b1, {(CoordBits-1){1'b0}}};
      2: return CoordBits'($urandom);
      default: return CoordBits'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic send_random(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = {any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
            any_coord(), any_coord(), any_coord(), any_coord()};
      if ($urandom_range(0, 15) == 0) begin
        it.p1_x = it.p0_x; it.p1_y = it.p0_y; it.p1_z = it.p0_z;
      end
      send_item(it);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_o);
      out_ready_i <= ($urandom_range(0, 3) != 0) || stim_done;
    end
  end

  initial begin
    in_item_t it;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    it = '0;
    send_item(it);
    it.p1_x = 24'sd4096; it.p2_x = 24'sd8192;
    send_item(it);
    it.p2_x = 24'sd0;
    send_item(it);
    it.p2_x = 24'sd4096; it.p2_y = 24'sd4096;
    send_item(it);
    it = '0;
    it.p0_x = {1'b1, 23'd0}; it.p1_x = {1'b0, {23{1'b1}}}; it.p2_x = {1'b1, 23'd0};
    it.p0_y = {1'b0, {23{1'b1}}}; it.p1_z = {1'b1, 23'd0}; it.p2_z = {1'b0, {23{1'b1}}};
    send_item(it);
    it = '1;
    send_item(it);
    send_random(150);
    drain();
    write_reg(CfgPeriodic, 1);
    write_reg(CfgBoxX, 23'd1);
    write_reg(CfgBoxY, 23'd40960);
    write_reg(CfgBoxZ, {23{1'b1}});
    it = '0;
    it.p1_x = 24'sd1; it.p2_x = 24'sd2;
    it.p1_y = 24'sd20480; it.p2_y = -24'sd1;
    it.p1_z = {1'b0, {23{1'b1}}}; it.p2_z = {1'b1, 23'd0};
    send_item(it);
    send_random(150);
    drain();
    write_reg(CfgBoxX, 23'd65536);
    write_reg(CfgBoxY, 23'd32768);
    write_reg(CfgBoxZ, 23'd50000);
    send_random(180);
    drain();
    write_reg(CfgBoxX, CfgDataBits'($urandom));
    write_reg(CfgBoxY, {23{1'b1}});
    write_reg(CfgBoxZ, 23'd1);
    send_random(100);
    drain();
    write_reg(CfgPeriodic, 0);
    send_random(60);
    stim_done = 1'b1;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end
endmodule
